/* rtl/core/intel_hex_image_loader_assert.svh */
// Assertion macros for the Intel HEX image loader.
// Used by the checker; depends on a clk and rst in scope.
`ifndef INTEL_HEX_IMAGE_LOADER_ASSERT_SVH
`define INTEL_HEX_IMAGE_LOADER_ASSERT_SVH

`define IHL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define IHL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/ihl_pkg.sv */
// Shared types, codes and helpers of the Intel HEX image loader.
// No dependencies.
package ihl_pkg;

  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] KIND_DATA = 8'h00;
  localparam logic [7:0] KIND_EOF  = 8'h01;
  localparam logic [7:0] KIND_ULBA = 8'h04;

  localparam logic [9:0] MIN_LINE = 10'd11;
  localparam logic [9:0] POS_MAX  = 10'd1023;

  localparam int F_PREFIX = 0;
  localparam int F_HEADER = 1;
  localparam int F_DATA   = 2;
  localparam int F_CHECK  = 3;

  localparam logic [3:0] ST_RUN      = 4'd0;
  localparam logic [3:0] ST_OK       = 4'd1;
  localparam logic [3:0] ST_PREFIX   = 4'd2;
  localparam logic [3:0] ST_SHORT    = 4'd3;
  localparam logic [3:0] ST_HDR_HEX  = 4'd4;
  localparam logic [3:0] ST_TRUNC    = 4'd5;
  localparam logic [3:0] ST_DATA_HEX = 4'd6;
  localparam logic [3:0] ST_SUM_HEX  = 4'd7;
  localparam logic [3:0] ST_SUM_BAD  = 4'd8;
  localparam logic [3:0] ST_TOO_BIG  = 4'd9;
  localparam logic [3:0] ST_BAD_EXT  = 4'd10;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
    logic copy;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       need_finish;
    logic       copy_start;
    logic       copy_done;
    logic       clear_done;
  } sts_t;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    if (c >= 8'h30 && c <= 8'h39) n = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) n = 5'(c - 8'h61) + 5'd10;
    else if (c >= 8'h41 && c <= 8'h46) n = 5'(c - 8'h41) + 5'd10;
    else n = 5'd16;
    return n;
  endfunction

endpackage

/* rtl/core/ihl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ihl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/ihl_ctrl.sv */
// Controller of the Intel HEX image loader: sequences accept, execute,
// record commit, image clear and result hand-off. Uses ihl_pkg.
module ihl_ctrl import ihl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic       reply, reply_next;

  always_comb begin
    state_next = state;
    reply_next = reply;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = reply ? S_OUT : S_IDLE;
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        case (sts.op)
          OP_FEED: state_next = sts.need_finish ? S_FIN : S_OUT;
          OP_READ: state_next = S_RDWAIT;
          OP_RESTART: begin
            state_next = S_CLEAR;
            reply_next = 1'b1;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_FIN: state_next = sts.copy_start ? S_COPY : S_OUT;
      S_COPY: if (sts.copy_done) state_next = S_OUT;
      S_RDWAIT: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.finish = (state == S_FIN);
  assign cmd.copy   = (state == S_COPY);
  assign cmd.clear  = (state == S_CLEAR);
endmodule

/* rtl/core/ihl_dp.sv */
// Datapath of the Intel HEX image loader: record parser, checks, record
// buffer, image store and clear/copy counters. Uses ihl_pkg and ihl_ram.
module ihl_dp import ihl_pkg::*; #(
  parameter int IMAGE_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_byte,
  input  logic        final_char,
  input  logic [12:0] read_address,
  output logic [3:0]  status,
  output logic [12:0] image_length,
  output logic [7:0]  read_data
);
  localparam int AW = $clog2(IMAGE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(IMAGE_BYTES - 1);
  localparam logic [16:0]   LIMIT     = 17'(IMAGE_BYTES);

  logic [1:0]    op_q;
  logic [7:0]    ch_q;
  logic          fin_q;
  logic [12:0]   addr_q;
  logic [3:0]    dstat;
  logic [AW-1:0] high_end;
  logic [15:0]   upper;
  logic [9:0]    pos;
  logic          line_open;
  logic [7:0]    count;
  logic [15:0]   offset;
  logic [7:0]    kind;
  logic [7:0]    sum;
  logic [3:0]    hnib;
  logic [3:0]    faults;
  logic [7:0]    b0, b1;
  logic [7:0]    ri, wi, ccount;
  logic          pend;
  logic [AW-1:0] wbase;
  logic [AW-1:0] clr;
  logic [7:0]    rd_q;

  logic [4:0]    nib;
  logic [9:0]    pos_m1;
  logic [8:0]    k, last, k_m4;
  logic          in_field, active, skip, end_lf, take, finish;
  logic [7:0]    byte_v;
  logic [3:0]    fault_hit;
  logic          rec_we;
  logic [7:0]    rec_rdata, img_rdata;
  logic [9:0]    need;
  logic [16:0]   end17, addr17;
  logic          too_large, in_range;
  logic [3:0]    fin_st;
  logic          img_we;
  logic [AW-1:0] img_waddr;
  logic [7:0]    img_wdata;

  assign nib    = nibble_of(ch_q);
  assign pos_m1 = pos - 10'd1;
  assign k      = pos_m1[9:1];
  assign last   = 9'd4 + {1'b0, count};
  assign k_m4   = k - 9'd4;
  assign in_field = (k <= 9'd3) || (k <= last);
  assign byte_v = {hnib, nib[3:0]};
  assign active = (op_q == OP_FEED) && (dstat == ST_RUN);
  assign end_lf = line_open && (ch_q == CH_LF);
  assign skip   = !line_open && ((ch_q == CH_CR) || (ch_q == CH_LF));
  assign take   = !skip && !end_lf;
  assign finish = end_lf || (take && fin_q);

  always_comb begin
    fault_hit = '0;
    if (k <= 9'd3) fault_hit[F_HEADER] = 1'b1;
    else if (k < last) fault_hit[F_DATA] = 1'b1;
    else fault_hit[F_CHECK] = 1'b1;
  end

  assign rec_we = cmd.exec && active && take && (pos != 10'd0) && in_field &&
                  !nib[4] && !pos[0] && (k >= 9'd4) && (k < last);

  assign need      = MIN_LINE + {1'b0, count, 1'b0};
  assign end17     = {1'b0, offset} + {9'd0, count};
  assign too_large = (upper != 16'd0) || (end17 >= LIMIT);
  assign addr17    = {4'd0, addr_q};
  assign in_range  = addr17 < LIMIT;

  always_comb begin
    if (faults[F_PREFIX]) fin_st = ST_PREFIX;
    else if (pos < MIN_LINE) fin_st = ST_SHORT;
    else if (faults[F_HEADER]) fin_st = ST_HDR_HEX;
    else if (pos < need) fin_st = ST_TRUNC;
    else if (faults[F_DATA]) fin_st = ST_DATA_HEX;
    else if (faults[F_CHECK]) fin_st = ST_SUM_HEX;
    else if (sum != 8'd0) fin_st = ST_SUM_BAD;
    else if (kind == KIND_DATA) fin_st = too_large ? ST_TOO_BIG : ST_RUN;
    else if (kind == KIND_EOF) fin_st = ST_OK;
    else if (kind == KIND_ULBA) fin_st = (count != 8'd2) ? ST_BAD_EXT : ST_RUN;
    else fin_st = ST_RUN;
  end

  assign sts.op          = op_q;
  assign sts.need_finish = active && finish;
  assign sts.copy_start  = (fin_st == ST_RUN) && (kind == KIND_DATA) &&
                           (count != 8'd0);
  assign sts.copy_done   = cmd.copy && (ri == ccount) && !pend;
  assign sts.clear_done  = cmd.clear && (clr == LAST_ADDR);

  assign img_we    = cmd.clear || (cmd.copy && pend);
  assign img_waddr = cmd.clear ? clr : wbase + AW'(wi);
  assign img_wdata = cmd.clear ? 8'd0 : rec_rdata;

  ihl_ram #(.WIDTH(8), .DEPTH(256)) u_rec (
    .clk(clk), .we(rec_we), .waddr(k_m4[7:0]), .wdata(byte_v),
    .raddr(ri), .rdata(rec_rdata)
  );

  ihl_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_img (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
    .raddr(addr17[AW-1:0]), .rdata(img_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      ch_q   <= char_byte;
      fin_q  <= final_char;
      addr_q <= read_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstat <= ST_RUN; high_end <= '0; upper <= '0; clr <= '0;
      pos <= '0; line_open <= 1'b0; count <= '0; offset <= '0; kind <= '0;
      sum <= '0; hnib <= '0; faults <= '0; rd_q <= '0;
      ri <= '0; wi <= '0; pend <= 1'b0; ccount <= '0;
    end else begin
      if (cmd.clear) clr <= clr + AW'(1);
      if (cmd.exec) begin
        rd_q <= 8'd0;
        if (op_q == OP_RESTART) begin
          dstat <= ST_RUN; high_end <= '0; upper <= '0; clr <= '0;
          pos <= '0; line_open <= 1'b0; count <= '0; offset <= '0; kind <= '0;
          sum <= '0; hnib <= '0; faults <= '0;
        end else if (active) begin
          if (take) begin
            line_open <= 1'b1;
            pos <= (pos < POS_MAX) ? pos + 10'd1 : POS_MAX;
            if (pos == 10'd0) begin
              if (ch_q != CH_COLON) faults[F_PREFIX] <= 1'b1;
            end else if (in_field) begin
              if (nib[4]) begin
                faults <= faults | fault_hit;
              end else if (pos[0]) begin
                hnib <= nib[3:0];
              end else begin
                sum <= sum + byte_v;
                case (k)
                  9'd0: count <= byte_v;
                  9'd1: offset[15:8] <= byte_v;
                  9'd2: offset[7:0] <= byte_v;
                  9'd3: kind <= byte_v;
                  9'd4: b0 <= byte_v;
                  9'd5: b1 <= byte_v;
                  default: ;
                endcase
              end
            end
          end
          if (fin_q && !finish) dstat <= ST_OK;
        end
      end
      if (cmd.finish) begin
        if (fin_st == ST_RUN && kind == KIND_DATA && end17[AW-1:0] > high_end)
          high_end <= end17[AW-1:0];
        if (fin_st == ST_RUN && kind == KIND_ULBA) upper <= {b0, b1};
        if (fin_st == ST_RUN && !sts.copy_start && fin_q) dstat <= ST_OK;
        else dstat <= fin_st;
        ccount <= count; wbase <= offset[AW-1:0];
        ri <= '0; wi <= '0; pend <= 1'b0;
        pos <= '0; line_open <= 1'b0; count <= '0; offset <= '0; kind <= '0;
        sum <= '0; hnib <= '0; faults <= '0;
      end
      if (cmd.copy) begin
        if (ri != ccount) begin
          ri <= ri + 8'd1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (pend) wi <= wi + 8'd1;
        if (sts.copy_done && fin_q) dstat <= ST_OK;
      end
      if (!cmd.exec && !cmd.load && op_q == OP_READ && !cmd.clear && !cmd.copy &&
          !cmd.finish && rd_q == 8'd0 && !sts.need_finish)
        rd_q <= in_range ? img_rdata : 8'd0;
    end
  end

  assign status       = dstat;
  assign image_length = 13'(high_end);
  assign read_data    = rd_q;
endmodule

/* rtl/core/intel_hex_image_loader.sv */
// Channel  | handshake            | beat fields
// in       | in_valid / in_stall  | operation, char_byte, final_char, read_address
// out      | out_valid / out_stall| status, image_length, read_data
// One beat at a time, taken in idle from the cycle after the previous result
// beat is accepted. A feed runs execute, then finish at a record end, then a
// copy of the record bytes to commit a data record; a read runs execute and
// a read wait. Restart and reset run an image clear pass over all IMAGE_BYTES
// addresses through the image RAM write port; no input beat is taken during it.
// A stalled output holds the block. Top level; uses ihl_pkg, ihl_ctrl, ihl_dp.
module intel_hex_image_loader import ihl_pkg::*; #(
  parameter int IMAGE_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_byte,
  input  logic        final_char,
  input  logic [12:0] read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [12:0] image_length,
  output logic [7:0]  read_data
);
  cmd_t cmd;
  sts_t sts;

  ihl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  ihl_dp #(.IMAGE_BYTES(IMAGE_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(operation), .char_byte(char_byte), .final_char(final_char),
    .read_address(read_address), .status(status),
    .image_length(image_length), .read_data(read_data)
  );
endmodule

/* rtl/core/ihl_checker.sv */
// Port-level checker for the Intel HEX image loader, bound to the top level.
// Uses intel_hex_image_loader_assert.svh.
`include "intel_hex_image_loader_assert.svh"
module ihl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  operation,
  input logic [7:0]  char_byte,
  input logic        final_char,
  input logic [12:0] read_address,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  status,
  input logic [12:0] image_length,
  input logic [7:0]  read_data
);
  `IHL_ASSERT_NEXT(a_no_result_next, in_valid && !in_stall, !out_valid)
  `IHL_ASSERT_NOW(a_one_in_flight, out_valid, in_stall)
  `IHL_ASSERT_NOW(a_status_code, out_valid, status <= 4'd10)
  `IHL_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(image_length) && $stable(read_data))
  `IHL_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(operation) && $stable(char_byte) && $stable(final_char) && $stable(read_address))
endmodule

bind intel_hex_image_loader ihl_checker u_ihl_checker (.*);

/* bench/tb_intel_hex_image_loader.sv */
// Self-checking bench for intel_hex_image_loader: feeds Intel HEX text,
// image reads and restarts, and predicts every result beat.
// Depends on ihl_pkg and the loader RTL only.
module tb_intel_hex_image_loader;
  import ihl_pkg::*;

  localparam int IMG_BYTES = 8192;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int TARGET_ITEMS = 1450;

  localparam int FLAW_NONE   = 0;
  localparam int FLAW_PREFIX = 1;
  localparam int FLAW_HEX    = 2;
  localparam int FLAW_CUT    = 3;
  localparam int FLAW_SUM    = 4;
  localparam int FLAW_TAIL   = 5;

  localparam logic [1:0] OP_BOGUS = 2'd3;

  typedef struct {
    logic [3:0]  st;
    logic [12:0] len;
    logic [7:0]  rd;
  } loader_result_t;

  class hex_loader_scoreboard;
    logic [7:0]  image[IMG_BYTES];
    logic [7:0]  rec[256];
    logic [15:0] upper;
    logic [12:0] high_end;
    int          line_pos;
    bit          in_line;
    logic [7:0]  cnt;
    logic [15:0] offs;
    logic [7:0]  kind;
    logic [7:0]  sum;
    logic [3:0]  hi_nib;
    logic [3:0]  faults;
    logic [3:0]  dstat;
    loader_result_t pending[$];
    int          errors;

    function void clear_line();
      line_pos = 0;
      in_line = 0;
      cnt = 0;
      offs = 0;
      kind = 0;
      sum = 0;
      hi_nib = 0;
      faults = 0;
    endfunction

    function void restart();
      foreach (image[i]) image[i] = 0;
      foreach (rec[i]) rec[i] = 0;
      upper = 0;
      high_end = 0;
      dstat = ST_RUN;
      clear_line();
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 16;
    endfunction

    function void take_char(logic [7:0] c);
      int k, last, n, fidx;
      logic [7:0] b;
      if (line_pos == 0) begin
        if (c != CH_COLON) faults[F_PREFIX] = 1'b1;
      end else begin
        k = (line_pos - 1) / 2;
        last = 4 + cnt;
        if (k <= 3 || k <= last) begin
          fidx = (k <= 3) ? F_HEADER : (k < last) ? F_DATA : F_CHECK;
          n = hex_value(c);
          if (n > 15) begin
            faults[fidx] = 1'b1;
          end else if (line_pos % 2 == 1) begin
            hi_nib = n[3:0];
          end else begin
            b = {hi_nib, n[3:0]};
            if (k == 0) cnt = b;
            else if (k == 1) offs[15:8] = b;
            else if (k == 2) offs[7:0] = b;
            else if (k == 3) kind = b;
            else if (k < last) rec[(k - 4) % 256] = b;
            sum = sum + b;
          end
        end
      end
      line_pos = (line_pos < POS_MAX) ? line_pos + 1 : POS_MAX;
    endfunction

    function void finish_line();
      longint base, stop;
      int need;
      need = MIN_LINE + 2 * cnt;
      if (faults[F_PREFIX]) dstat = ST_PREFIX;
      else if (line_pos < MIN_LINE) dstat = ST_SHORT;
      else if (faults[F_HEADER]) dstat = ST_HDR_HEX;
      else if (line_pos < need) dstat = ST_TRUNC;
      else if (faults[F_DATA]) dstat = ST_DATA_HEX;
      else if (faults[F_CHECK]) dstat = ST_SUM_HEX;
      else if (sum != 0) dstat = ST_SUM_BAD;
      else if (kind == KIND_DATA) begin
        base = (longint'(upper) << 16) + offs;
        stop = base + cnt;
        if (stop >= IMG_BYTES) begin
          dstat = ST_TOO_BIG;
        end else begin
          for (int i = 0; i < cnt; i++) image[base + i] = rec[i];
          if (stop > high_end) high_end = stop[12:0];
        end
      end else if (kind == KIND_EOF) begin
        dstat = ST_OK;
      end else if (kind == KIND_ULBA) begin
        if (cnt != 2) dstat = ST_BAD_EXT;
        else upper = {rec[0], rec[1]};
      end
      clear_line();
    endfunction

    function void note_beat(logic [1:0] op, logic [7:0] c, logic fin, logic [12:0] addr);
      loader_result_t r;
      r.rd = 0;
      if (op == OP_FEED) begin
        if (dstat == ST_RUN) begin
          if (in_line && c == CH_LF) begin
            finish_line();
          end else if (!in_line && (c == CH_CR || c == CH_LF)) begin
          end else begin
            in_line = 1;
            take_char(c);
            if (fin) finish_line();
          end
          if (fin && dstat == ST_RUN) dstat = ST_OK;
        end
      end else if (op == OP_READ) begin
        if (addr < IMG_BYTES) r.rd = image[addr];
      end else if (op == OP_RESTART) begin
        restart();
      end
      r.st = dstat;
      r.len = high_end;
      pending.push_back(r);
    endfunction

    function void check_result(logic [3:0] st, logic [12:0] len, logic [7:0] rd);
      loader_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
      if (len !== e.len) begin
        $error("image_length expected %0d actual %0d", e.len, len);
        errors++;
      end
      if (rd !== e.rd) begin
        $error("read_data expected %0d actual %0d", e.rd, rd);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  operation = OP_FEED;
  logic [7:0]  char_byte = 0;
  logic        final_char = 0;
  logic [12:0] read_address = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [3:0]  status;
  logic [12:0] image_length;
  logic [7:0]  read_data;

  hex_loader_scoreboard sb = new;
  logic [7:0] text_q[$];
  int items_sent = 0;
  int send_pct = 13;
  int recv_pct = 64;
  int cycles = 0;

  intel_hex_image_loader #(.IMAGE_BYTES(IMG_BYTES)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .char_byte(char_byte),
    .final_char(final_char), .read_address(read_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .image_length(image_length), .read_data(read_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_beat(operation, char_byte, final_char, read_address);
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, image_length, read_data);
  end

  always @(negedge clk) out_stall = ($urandom_range(99) < recv_pct);

  task automatic put_beat(logic [1:0] op, logic [7:0] c, logic fin, logic [12:0] a);
    operation = op;
    char_byte = c;
    final_char = fin;
    read_address = a;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
    if ($urandom_range(99) < send_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_hex(logic [7:0] b, bit lower);
    logic [3:0] n;
    for (int h = 1; h >= 0; h--) begin
      n = b[h*4 +: 4];
      if (n < 10) text_q.push_back(8'("0" + n));
      else text_q.push_back(8'((lower ? "a" : "A") + n - 10));
    end
  endfunction

  task automatic add_record(logic [7:0] kind, int cnt, logic [15:0] off,
                            logic [15:0] seg, int flaw);
    logic [7:0] bytes[$];
    logic [7:0] s;
    int start;
    bit lower;
    lower = 1'($urandom_range(1));
    bytes = {cnt[7:0], off[15:8], off[7:0], kind};
    for (int i = 0; i < cnt; i++) begin
      if (kind == KIND_ULBA && i < 2) bytes.push_back(i == 0 ? seg[15:8] : seg[7:0]);
      else bytes.push_back(8'($urandom_range(255)));
    end
    s = 0;
    foreach (bytes[i]) s += bytes[i];
    s = -s;
    if (flaw == FLAW_SUM) s = s + 8'($urandom_range(1, 255));
    bytes.push_back(s);
    start = text_q.size();
    if (flaw == FLAW_PREFIX) begin
      do s = 8'($urandom_range(255)); while (s == CH_COLON || s == CH_LF || s == CH_CR);
      text_q.push_back(s);
    end else begin
      text_q.push_back(CH_COLON);
    end
    foreach (bytes[i]) push_hex(bytes[i], lower);
    if (flaw == FLAW_HEX) begin
      do s = 8'($urandom_range(255)); while (sb.hex_value(s) < 16 || s == CH_LF);
      text_q[start + 1 + $urandom_range(text_q.size() - start - 2)] = s;
    end
    if (flaw == FLAW_CUT) repeat ($urandom_range(1, 12))
      if (text_q.size() > start + 1) void'(text_q.pop_back());
    if (flaw == FLAW_TAIL) repeat ($urandom_range(1, 5))
      text_q.push_back(8'("x" + $urandom_range(3)));
    if ($urandom_range(1)) text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    if ($urandom_range(9) == 0) text_q.push_back(CH_CR);
  endtask

  task automatic send_text(bit mark_final);
    foreach (text_q[i]) begin
      if ($urandom_range(99) < 6) put_beat(OP_READ, 8'd0, 1'b0, 13'($urandom_range(0, 63)));
      put_beat(OP_FEED, text_q[i], mark_final && i == text_q.size() - 1,
               13'($urandom_range(8191)));
    end
  endtask

  task automatic random_file();
    int r, cnt, flaw;
    logic [15:0] off;
    text_q.delete();
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(99);
      flaw = ($urandom_range(99) < 88) ? FLAW_NONE : $urandom_range(FLAW_PREFIX, FLAW_TAIL);
      if (r < 65) begin
        cnt = ($urandom_range(15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
        off = ($urandom_range(19) == 0) ? 16'($urandom_range(IMG_BYTES - cnt, 65535))
                                        : 16'($urandom_range(0, IMG_BYTES - 1 - cnt));
        add_record(KIND_DATA, cnt, off, 16'd0, flaw);
      end else if (r < 80) begin
        add_record(KIND_ULBA, ($urandom_range(4) == 0) ? $urandom_range(0, 4) : 2,
                   16'($urandom), ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0, flaw);
      end else begin
        add_record(8'($urandom_range(2, 255)), $urandom_range(0, 4), 16'($urandom),
                   16'd0, flaw);
      end
    end
    if ($urandom_range(99) < 60) add_record(KIND_EOF, 0, 16'd0, 16'd0, FLAW_NONE);
    if (text_q.size() > 0 && $urandom_range(99) < 30) void'(text_q.pop_back());
    send_text($urandom_range(99) < 80);
    repeat ($urandom_range(2, 8))
      put_beat(OP_READ, 8'd0, 1'($urandom_range(1)), 13'($urandom_range(8191)));
    if ($urandom_range(9) == 0)
      put_beat(OP_BOGUS, 8'($urandom), 1'($urandom_range(1)), 13'($urandom));
    if ($urandom_range(99) < 75)
      put_beat(OP_RESTART, 8'($urandom), 1'($urandom_range(1)), 13'($urandom));
  endtask

  initial begin
    sb.restart();
    sb.errors = 0;
    repeat (2) @(negedge clk);
    rst = 0;

    text_q.delete();
    push_text(":0100000055AA");
    text_q.push_back(CH_LF);
    send_text(0);
    put_beat(OP_READ, 8'd0, 1'b0, 13'd0);
    put_beat(OP_READ, 8'hFF, 1'b1, 13'h1FFF);
    put_beat(OP_BOGUS, 8'hFF, 1'b1, 13'h1FFF);
    text_q.delete();
    push_text(":00000001FF");
    send_text(1);
    put_beat(OP_RESTART, 8'd0, 1'b0, 13'd0);
    drain();

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent < TARGET_ITEMS / 3) begin
        send_pct = 13;
        recv_pct = 64;
      end else if (items_sent < 2 * TARGET_ITEMS / 3) begin
        send_pct = 64;
        recv_pct = 13;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      random_file();
      if ($urandom_range(3) == 0) drain();
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
